@@ design/rwtc_pkg.sv @@
// Shared types, token codes and the reserved-word table of the romaji word classifier.
// No dependencies; every other file of the block depends on this package.
package rwtc_pkg;

  // Token codes of a result transaction
  typedef enum logic [3:0] {
    TOK_ERROR       = 4'd0,
    TOK_WORD1       = 4'd1,
    TOK_WORD2       = 4'd2,
    TOK_PERIOD      = 4'd3,
    TOK_EOFM        = 4'd4,
    TOK_VERB        = 4'd5,
    TOK_VERBNEG     = 4'd6,
    TOK_VERBPAST    = 4'd7,
    TOK_VERBPASTNEG = 4'd8,
    TOK_IS          = 4'd9,
    TOK_WAS         = 4'd10,
    TOK_OBJECT      = 4'd11,
    TOK_SUBJECT     = 4'd12,
    TOK_DESTINATION = 4'd13,
    TOK_PRONOUN     = 4'd14,
    TOK_CONNECTOR   = 4'd15
  } token_t;

  // Syllable automaton states, one-hot
  typedef enum logic [7:0] {
    ST_START = 8'b0000_0001,
    ST_PAIR  = 8'b0000_0010,
    ST_S     = 8'b0000_0100,
    ST_T     = 8'b0000_1000,
    ST_C     = 8'b0001_0000,
    ST_GLIDE = 8'b0010_0000,
    ST_VOWEL = 8'b0100_0000,
    ST_N     = 8'b1000_0000
  } syl_state_t;

  localparam int RSV_NUM   = 19;
  localparam int RSV_CHARS = 12;
  localparam logic [3:0] POS_MAX = 4'd13;
  localparam logic [4:0] RSV_EOFM = 5'd18;

  // Reserved words, right-justified in a 12-character field
  localparam logic [RSV_CHARS*8-1:0] RSV_TEXT [RSV_NUM] = '{
    "masu", "masen", "mashita", "masendeshita", "desu", "deshita",
    "o", "wa", "ni", "watashi", "anata", "kare", "kanojo", "sore",
    "mata", "soshite", "shikashi", "dakara", "eofm"
  };

  localparam logic [3:0] RSV_LEN [RSV_NUM] = '{
    4'd4, 4'd5, 4'd7, 4'd12, 4'd4, 4'd7, 4'd1, 4'd2, 4'd2,
    4'd7, 4'd5, 4'd4, 4'd6, 4'd4, 4'd4, 4'd7, 4'd8, 4'd6, 4'd4
  };

  localparam token_t RSV_TYPE [RSV_NUM] = '{
    TOK_VERB, TOK_VERBNEG, TOK_VERBPAST, TOK_VERBPASTNEG, TOK_IS, TOK_WAS,
    TOK_OBJECT, TOK_SUBJECT, TOK_DESTINATION,
    TOK_PRONOUN, TOK_PRONOUN, TOK_PRONOUN, TOK_PRONOUN, TOK_PRONOUN,
    TOK_CONNECTOR, TOK_CONNECTOR, TOK_CONNECTOR, TOK_CONNECTOR, TOK_EOFM
  };

  // Status of the reserved-word tracker for the current character
  typedef struct packed {
    logic   first;
    logic   hit;
    logic   eofm;
    token_t rtype;
  } rsv_status_t;

  // Character at a position of a reserved word; zero past its end
  function automatic logic [7:0] rsv_char(input logic [4:0] idx, input logic [3:0] pos);
    logic [3:0] off;
    logic [6:0] base;
    logic [RSV_CHARS*8-1:0] text;
    off  = RSV_LEN[idx] - 4'd1 - pos;
    base = {off, 3'b000};
    text = RSV_TEXT[idx];
    if (pos < RSV_LEN[idx]) begin
      return text[base +: 8];
    end else begin
      return 8'h00;
    end
  endfunction

endpackage

@@ design/rwtc_if.sv @@
// Stream channels of the romaji word classifier: character input and token output.
// Depends on rwtc_pkg for the token type.
interface rwtc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       last;

  modport source (output valid, output ch, output last, input ready);
  modport sink   (input valid, input ch, input last, output ready);
endinterface

interface rwtc_out_if;
  logic             valid;
  logic             ready;
  rwtc_pkg::token_t token_type;

  modport source (output valid, output token_type, input ready);
  modport sink   (input valid, input token_type, output ready);
endinterface

@@ design/rwtc_syllable.sv @@
// Romaji syllable automaton with its reject flag, updated once per character.
// Depends on rwtc_pkg for the state encoding.
module rwtc_syllable (
  input  logic       clk,
  input  logic       rst,
  input  logic       step,
  input  logic [7:0] ch,
  input  logic       last,
  output logic       accept
);
  import rwtc_pkg::*;

  syl_state_t state, state_next, trans;
  logic       rejected, rejected_next;
  logic       has_trans;
  logic       vowel, solo, pair, boundary;

  // Classify the character
  always_comb begin
    vowel = (ch == "a") || (ch == "e") || (ch == "i") || (ch == "o") || (ch == "u");
    solo  = (ch == "d") || (ch == "j") || (ch == "w") || (ch == "y") || (ch == "z");
    pair  = (ch == "b") || (ch == "g") || (ch == "h") || (ch == "k") || (ch == "m") ||
            (ch == "p") || (ch == "r");
    boundary = (state == ST_START) || (state == ST_VOWEL) || (state == ST_N);
  end

  // Find the transition, in priority order
  always_comb begin
    has_trans = 1'b1;
    trans     = state;
    if (boundary && solo) begin
      trans = ST_GLIDE;
    end else if ((state == ST_S || state == ST_C) && ch == "h") begin
      trans = ST_GLIDE;
    end else if (state == ST_T && ch == "s") begin
      trans = ST_GLIDE;
    end else if (state == ST_PAIR && ch == "y") begin
      trans = ST_GLIDE;
    end else if (boundary && ch == "c") begin
      trans = ST_C;
    end else if (state == ST_VOWEL && ch == "n") begin
      trans = ST_N;
    end else if ((state == ST_START || state == ST_N) && (pair || ch == "n")) begin
      trans = ST_PAIR;
    end else if (state == ST_VOWEL && pair) begin
      trans = ST_PAIR;
    end else if (boundary && ch == "t") begin
      trans = ST_T;
    end else if (boundary && ch == "s") begin
      trans = ST_S;
    end else if (state != ST_C && vowel) begin
      trans = ST_VOWEL;
    end else begin
      has_trans = 1'b0;
    end
  end

  // Advance unless already rejected
  always_comb begin
    state_next    = state;
    rejected_next = rejected;
    if (!rejected) begin
      if (has_trans) begin
        state_next = trans;
      end else begin
        rejected_next = 1'b1;
      end
    end
    accept = !rejected_next && (state_next == ST_VOWEL || state_next == ST_N);
  end

  // Hold between characters, drop back to start after a word
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_START;
      rejected <= 1'b0;
    end else if (step) begin
      if (last) begin
        state    <= ST_START;
        rejected <= 1'b0;
      end else begin
        state    <= state_next;
        rejected <= rejected_next;
      end
    end
  end

endmodule

@@ design/rwtc_reserved.sv @@
// Position counter and per-word match flags against the reserved-word table.
// Depends on rwtc_pkg for the table and the status struct.
module rwtc_reserved (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  step,
  input  logic [7:0]            ch,
  input  logic                  last,
  output rwtc_pkg::rsv_status_t status
);
  import rwtc_pkg::*;

  logic [3:0]         pos, pos_next;
  logic [RSV_NUM-1:0] flags, flags_next, keep;
  logic [4:0]         hit_idx;
  logic               hit;

  // Compare the character against every word at the current position
  for (genvar i = 0; i < RSV_NUM; i++) begin : g_keep
    assign keep[i] = (pos < RSV_LEN[i]) && (ch == rsv_char(5'(i), pos));
  end

  assign flags_next = flags & keep;
  assign pos_next   = (pos < POS_MAX) ? pos + 4'd1 : pos;

  // Pick the lowest-index word that matches in full
  always_comb begin
    hit     = 1'b0;
    hit_idx = 5'd0;
    for (int i = RSV_NUM - 1; i >= 0; i--) begin
      if (flags_next[i] && RSV_LEN[i] == pos_next) begin
        hit     = 1'b1;
        hit_idx = 5'(i);
      end
    end
    status.first = (pos == 4'd0);
    status.hit   = hit;
    status.eofm  = hit && (hit_idx == RSV_EOFM);
    status.rtype = RSV_TYPE[hit_idx];
  end

  // Advance per character, clear after a word
  always_ff @(posedge clk) begin
    if (rst) begin
      pos   <= 4'd0;
      flags <= '1;
    end else if (step) begin
      if (last) begin
        pos   <= 4'd0;
        flags <= '1;
      end else begin
        pos   <= pos_next;
        flags <= flags_next;
      end
    end
  end

endmodule

@@ design/romaji_word_token_classifier.sv @@
// Romaji word token classifier: one character per cycle in, one token per word out.
// Path: a character is registered in the input register, then classified into the result
// register, which drives the token. Throughput: one character every cycle, set by the
// automaton and match-flag update that act on each character; a final character
// waits only while an earlier token is held and the output is not ready.
// Reset (synchronous, rst high) empties both registers and returns the word state to start.
module romaji_word_token_classifier (
  input  logic        clk,
  input  logic        rst,
  rwtc_in_if.sink     word_in,
  rwtc_out_if.source  token_out
);
  import rwtc_pkg::*;

  logic        in_valid;
  logic [7:0]  in_ch;
  logic        in_last;
  logic        advance;
  logic        out_valid;
  token_t      out_token;
  token_t      token_next;
  logic        accept;
  rsv_status_t rsv;

  // Move the registered character on; a non-final one needs no output slot
  assign advance = in_valid && (!in_last || !out_valid || token_out.ready);
  assign word_in.ready = !in_valid || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (word_in.ready) begin
      in_valid <= word_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (word_in.valid && word_in.ready) begin
      in_ch   <= word_in.ch;
      in_last <= word_in.last;
    end
  end

  rwtc_syllable u_syllable (
    .clk    (clk),
    .rst    (rst),
    .step   (advance),
    .ch     (in_ch),
    .last   (in_last),
    .accept (accept)
  );

  rwtc_reserved u_reserved (
    .clk    (clk),
    .rst    (rst),
    .step   (advance),
    .ch     (in_ch),
    .last   (in_last),
    .status (rsv)
  );

  // Decide the token in priority order
  always_comb begin
    if (rsv.eofm) begin
      token_next = TOK_EOFM;
    end else if (in_ch == "E" || in_ch == "I") begin
      token_next = TOK_WORD2;
    end else if (accept) begin
      token_next = rsv.hit ? rsv.rtype : TOK_WORD1;
    end else if (rsv.first && in_ch == ".") begin
      token_next = TOK_PERIOD;
    end else begin
      token_next = TOK_ERROR;
    end
  end

  // Result register: load on a final character, clear once the transaction completes
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && in_last) begin
      out_valid <= 1'b1;
    end else if (token_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_last) begin
      out_token <= token_next;
    end
  end

  assign token_out.valid      = out_valid;
  assign token_out.token_type = out_token;

endmodule
